// File: rtl/radix64_codec_macros.svh
// Assertion macros for the radix-64 codec.
// Used by the top level; expects clk and arst_n in the including scope.
`ifndef RADIX64_CODEC_MACROS_SVH
`define RADIX64_CODEC_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define R64_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("radix64_codec: same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define R64_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("radix64_codec: next-cycle check failed");

`endif

// File: rtl/r64_pkg.sv
// Shared types, constants and symbol mapping functions for the radix-64 codec.
// No dependencies; used by the step logic, the top level and the testbench.
`default_nettype none

package r64_pkg;

	localparam int unsigned CodeW  = 6;
	localparam int unsigned CountW = 3;
	localparam int unsigned ByteW  = 8;

	// Direction register codes
	localparam logic DirEncode = 1'b0;
	localparam logic DirDecode = 1'b1;

	// Action codes of the input word
	localparam logic ActData = 1'b0;
	localparam logic ActEnd  = 1'b1;

	// Message state carried between words
	typedef struct packed {
		logic [CodeW-1:0]  bits;
		logic [CountW-1:0] count;
		logic              halted;
	} r64_state_t;

	// One result word
	typedef struct packed {
		logic [ByteW-1:0] value;
		logic             last;
	} r64_word_t;

	// Outcome of processing one input word
	typedef struct packed {
		logic [1:0] n;
		r64_word_t  r0;
		r64_word_t  r1;
		r64_state_t nxt;
	} r64_step_t;

	// 6-bit code to ASCII symbol: digits, upper case, lower case, '+', '/'
	function automatic logic [ByteW-1:0] code_to_char(input logic [CodeW-1:0] c);
		logic [ByteW-1:0] cx;
		cx = {2'b00, c};
		if (c < 6'd10) begin
			return 8'h30 + cx;
		end else if (c < 6'd36) begin
			return 8'h41 + cx - 8'd10;
		end else if (c < 6'd62) begin
			return 8'h61 + cx - 8'd36;
		end else if (c == 6'd62) begin
			return 8'h2b;
		end else begin
			return 8'h2f;
		end
	endfunction

	// ASCII symbol to code; bit 6 set marks a character outside the alphabet
	function automatic logic [CodeW:0] char_to_code(input logic [ByteW-1:0] ch);
		logic [ByteW-1:0] d;
		d = 8'h00;
		case (ch) inside
			[8'h30:8'h39]: begin
				d = ch - 8'h30;
				return {1'b0, d[CodeW-1:0]};
			end
			[8'h41:8'h5a]: begin
				d = ch - 8'h41 + 8'd10;
				return {1'b0, d[CodeW-1:0]};
			end
			[8'h61:8'h7a]: begin
				d = ch - 8'h61 + 8'd36;
				return {1'b0, d[CodeW-1:0]};
			end
			8'h2b: return {1'b0, 6'd62};
			8'h2f: return {1'b0, 6'd63};
			default: return {1'b1, 6'd0};
		endcase
	endfunction

endpackage

`default_nettype wire

// File: rtl/r64_in_if.sv
// Input channel of the radix-64 codec: valid/ready with action and data.
// Depends on nothing.
`default_nettype none

interface r64_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] data;

	modport source (output valid, output action, output data, input ready);
	modport sink (input valid, input action, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/r64_out_if.sv
// Result channel of the radix-64 codec: valid/ready with value and last.
// Depends on nothing.
`default_nettype none

interface r64_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] value;
	logic       last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/radix64_codec.sv
// Radix-64 codec top level: input register, step logic, two-word result queue.
// Uses r64_pkg, r64_in_if, r64_out_if, r64_step and radix64_codec_macros.svh.
//
// Radix-64 codec without padding, alphabet 0-9, A-Z, a-z, '+', '/'. Write cfg_wdata
// with cfg_we to pick the direction (0 encode bytes, 1 decode characters); every write
// also starts a new message. An input word with action 1 ends the message: while
// encoding it flushes any held bits as one last symbol. The block takes one input word
// per cycle while the result queue has room. A word is held in the input register and
// then its results enter a two-entry result queue, whose head is offered on the
// result channel. The result channel moves one word per cycle while dout.ready is
// high, so an encoded byte that yields two symbols holds the channel for two words.
`default_nettype none
`include "radix64_codec_macros.svh"

module radix64_codec (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_we,
	input  wire logic  cfg_wdata,
	r64_in_if.sink     din,
	r64_out_if.source  dout
);
	import r64_pkg::*;

	logic       dir_q;
	r64_state_t st_q;
	logic       in_v_s1;
	logic       action_s1;
	logic [7:0] data_s1;
	r64_word_t  ent0_q, ent1_q;
	logic [1:0] cnt_q;
	r64_step_t  step;
	logic       pop;
	logic       take;
	logic [2:0] room;
	logic [1:0] pos;
	logic [1:0] cnt_n;
	r64_word_t  ent0_n, ent1_n;

	r64_step u_step (
		.direction (dir_q),
		.action    (action_s1),
		.data      (data_s1),
		.st        (st_q),
		.res       (step)
	);

	// Handshakes
	assign pop       = dout.valid && dout.ready;
	assign room      = 3'd2 - {1'b0, cnt_q} + {2'b00, pop};
	assign take      = in_v_s1 && ({1'b0, step.n} <= room);
	assign din.ready = !in_v_s1 || take;
	assign dout.valid = (cnt_q != 2'd0);
	assign dout.value = ent0_q.value;
	assign dout.last  = ent0_q.last;

	// Result queue next contents: drop head on pop, append new words
	always_comb begin
		ent0_n = pop ? ent1_q : ent0_q;
		ent1_n = ent1_q;
		pos    = cnt_q - {1'b0, pop};
		cnt_n  = pos;
		if (take && step.n != 2'd0) begin
			if (pos == 2'd0) begin
				ent0_n = step.r0;
				ent1_n = step.r1;
			end else begin
				ent1_n = step.r0;
			end
			cnt_n = pos + step.n;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q   <= DirEncode;
			st_q    <= '0;
			in_v_s1 <= 1'b0;
			cnt_q   <= 2'd0;
		end else begin
			if (cfg_we) begin
				dir_q <= cfg_wdata;
				st_q  <= '0;
			end else if (take) begin
				st_q <= step.nxt;
			end
			if (din.valid && din.ready) begin
				in_v_s1 <= 1'b1;
			end else if (take) begin
				in_v_s1 <= 1'b0;
			end
			cnt_q <= cnt_n;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			action_s1 <= din.action;
			data_s1   <= din.data;
		end
		ent0_q <= ent0_n;
		ent1_q <= ent1_n;
	end

	// Checks
	`R64_ASSERT_NOW(a_queue_bound, 1'b1, cnt_q != 2'd3)
	`R64_ASSERT_NOW(a_hold_blocks, in_v_s1 && !take, !din.ready)
	`R64_ASSERT_NOW(a_halt_decode, st_q.halted, dir_q == DirDecode)
	`R64_ASSERT_NEXT(a_enc_count, !cfg_we && dir_q == DirEncode && st_q.count == 3'd0
		&& st_q.bits == 6'd0, st_q.count == 3'd0 || st_q.count == 3'd2
		|| st_q.count == 3'd4 || dir_q == DirDecode)

endmodule

`default_nettype wire

// File: rtl/r64_step.sv
// Combinational step of the radix-64 codec: one input word plus held state
// gives up to two result words and the next state. Uses r64_pkg.
`default_nettype none

module r64_step (
	input  wire logic                direction,
	input  wire logic                action,
	input  wire logic [7:0]          data,
	input  wire r64_pkg::r64_state_t st,
	output r64_pkg::r64_step_t       res
);
	import r64_pkg::*;

	logic [13:0] e_acc0, e_acc1, e_acc2;
	logic [3:0]  e_a0, e_a1, e_a2;
	logic [5:0]  e_s0, e_s1;
	logic        e_two;
	logic [6:0]  d_code;
	logic [13:0] d_acc0, d_acc1;
	logic [3:0]  d_a0, d_a1;
	logic [7:0]  d_val;
	logic        d_out;
	logic [2:0]  f_sh;
	logic [5:0]  f_sym;

	// Encode: add 8 bits, peel off one or two 6-bit groups from the top
	always_comb begin
		e_acc0 = {st.bits, data};
		e_a0   = {1'b0, st.count} + 4'd8;
		e_a1   = e_a0 - 4'd6;
		e_s0   = 6'(e_acc0 >> e_a1);
		e_acc1 = e_acc0 & ~(14'h3fff << e_a1);
		e_two  = (e_a1 >= 4'd6);
		if (e_two) begin
			e_a2 = e_a1 - 4'd6;
		end else begin
			e_a2 = e_a1;
		end
		e_s1   = 6'(e_acc1 >> e_a2);
		e_acc2 = e_two ? (e_acc1 & ~(14'h3fff << e_a2)) : e_acc1;
	end

	// Decode: add 6 bits, emit a byte once 8 are gathered
	always_comb begin
		d_code = char_to_code(data);
		d_acc0 = {2'b00, st.bits, d_code[5:0]};
		d_a0   = {1'b0, st.count} + 4'd6;
		d_out  = (d_a0 >= 4'd8);
		d_a1   = d_out ? (d_a0 - 4'd8) : d_a0;
		d_val  = 8'(d_acc0 >> d_a1);
		d_acc1 = d_out ? (d_acc0 & ~(14'h3fff << d_a1)) : d_acc0;
	end

	// Flush: held bits moved to the top of one symbol
	always_comb begin
		f_sh  = 3'd6 - st.count;
		f_sym = st.bits << f_sh;
	end

	// Select the outcome
	always_comb begin
		res           = '0;
		res.nxt       = st;
		res.r1.last   = 1'b1;
		if (action == ActEnd) begin
			res.nxt = '0;
			if (direction == DirEncode && st.count != 3'd0 && st.count < 3'd6) begin
				res.n        = 2'd1;
				res.r0.value = code_to_char(f_sym);
				res.r0.last  = 1'b1;
			end
		end else if (direction == DirEncode) begin
			res.n          = e_two ? 2'd2 : 2'd1;
			res.r0.value   = code_to_char(e_s0);
			res.r0.last    = !e_two;
			res.r1.value   = code_to_char(e_s1);
			res.nxt.bits   = e_acc2[5:0];
			res.nxt.count  = e_a2[2:0];
		end else if (!st.halted) begin
			if (d_code[6]) begin
				res.nxt.halted = 1'b1;
			end else begin
				res.n         = d_out ? 2'd1 : 2'd0;
				res.r0.value  = d_val;
				res.r0.last   = 1'b1;
				res.nxt.bits  = d_acc1[5:0];
				res.nxt.count = d_a1[2:0];
			end
		end
	end

endmodule

`default_nettype wire

// File: test/radix64_codec_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for radix64_codec: encode and decode messages under random stalls.
// Depends on r64_pkg, r64_in_if, r64_out_if and the radix64_codec top level.

// Tracks the codec's message state and holds the result words it should produce
class Radix64Scoreboard;
	logic [7:0] sym_tab[64];
	logic [6:0] code_tab[256];
	logic       dir;
	logic [5:0] held;
	logic [2:0] nheld;
	logic       stopped;
	r64_pkg::r64_word_t expected_q[$];
	int errors;
	int checked;

	function new();
		string abc;
		abc = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz+/";
		for (int c = 0; c < 256; c++) begin
			code_tab[c] = 7'h40;
		end
		for (int i = 0; i < 64; i++) begin
			sym_tab[i] = abc[i];
			code_tab[abc[i]] = i[6:0];
		end
		dir = r64_pkg::DirEncode;
		held = '0;
		nheld = '0;
		stopped = 1'b0;
		errors = 0;
		checked = 0;
	endfunction

	function logic [7:0] symbol_of(int code);
		return sym_tab[code];
	endfunction

	function bit is_symbol(logic [7:0] ch);
		return !code_tab[ch][6];
	endfunction

	// Any write of the direction starts a new message
	function void set_direction(logic d);
		dir = d;
		held = '0;
		nheld = '0;
		stopped = 1'b0;
	endfunction

	function void push_word(logic [7:0] value, logic last);
		r64_pub_word(value, last);
	endfunction

	function void r64_pub_word(logic [7:0] value, logic last);
		r64_pkg::r64_word_t w;
		w.value = value;
		w.last = last;
		expected_q.push_back(w);
	endfunction

	// Work out the result words of one accepted input word
	function void note_input(logic act, logic [7:0] dat);
		logic [13:0] acc;
		logic [5:0]  grp[2];
		logic [5:0]  tail;
		logic [6:0]  code;
		int          a;
		int          n;
		if (act == r64_pkg::ActEnd) begin
			// encoding flushes held bits, left aligned, as one last symbol
			if (dir == r64_pkg::DirEncode && nheld != 0) begin
				tail = held << (6 - nheld);
				r64_pub_word(sym_tab[tail], 1'b1);
			end
			set_direction(dir);
			return;
		end
		if (dir == r64_pkg::DirEncode) begin
			acc = {held, dat};
			a = nheld + 8;
			n = 0;
			while (a >= 6 && n < 2) begin
				a -= 6;
				grp[n] = acc >> a;
				acc = acc & ((14'd1 << a) - 14'd1);
				n++;
			end
			for (int k = 0; k < n; k++) begin
				r64_pub_word(sym_tab[grp[k]], k == n - 1);
			end
			held = acc[5:0];
			nheld = a[2:0];
			return;
		end
		// decoding: ignored after a character outside the alphabet
		if (stopped) begin
			return;
		end
		code = code_tab[dat];
		if (code[6]) begin
			stopped = 1'b1;
			return;
		end
		acc = {2'b00, held, code[5:0]};
		a = nheld + 6;
		if (a >= 8) begin
			a -= 8;
			r64_pub_word(acc >> a, 1'b1);
			acc = acc & ((14'd1 << a) - 14'd1);
		end
		held = acc[5:0];
		nheld = a[2:0];
	endfunction

	// Compare one accepted result word with the oldest expected one
	function void check_result(logic [7:0] value, logic last);
		r64_pkg::r64_word_t w;
		if (expected_q.size() == 0) begin
			errors++;
			if (errors <= 50)
				$display("%0t: expected no result word, got value %h last %b",
					$time, value, last);
			return;
		end
		w = expected_q.pop_front();
		checked++;
		if (w.value !== value || w.last !== last) begin
			errors++;
			if (errors <= 50)
				$display("%0t: expected value %h last %b, got value %h last %b",
					$time, w.value, w.last, value, last);
		end
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	// Expected words that never arrived
	function void final_check();
		r64_pkg::r64_word_t w;
		while (expected_q.size() != 0) begin
			w = expected_q.pop_front();
			errors++;
			if (errors <= 50)
				$display("%0t: expected value %h last %b, got no result word",
					$time, w.value, w.last);
		end
	endfunction
endclass

module radix64_codec_tb;
	import r64_pkg::*;

	localparam int RandomItems = 1300;
	// drain after the last expected word
	localparam int Drain = 8;
	// bound for the slowest run (sender gaps, two results each fully stalled)
	localparam int CycleLimit = 400000;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	r64_in_if  din_if ();
	r64_out_if dout_if ();

	radix64_codec DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.din       (din_if),
		.dout      (dout_if)
	);

	Radix64Scoreboard sb = new();

	int   items = 0;
	int   dir_writes = 0;
	int   cycles = 0;
	bit   src_steady = 1'b0;
	bit   sink_steady = 1'b0;
	logic dir_now = DirEncode;

	always #4 clk = ~clk;

	// Known values on every input from time zero, then reset is released
	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		din_if.valid <= 1'b0;
		din_if.action <= ActData;
		din_if.data <= 8'h00;
		dout_if.ready <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles == CycleLimit) begin
			$display("%0t: timeout after %0d cycles, %0d words still expected",
				$time, cycles, sb.pending());
			$display("radix64_codec_tb: done, errors");
			$finish;
		end
	end

	// Both channels sampled in one process: input words noted before results checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (din_if.valid && din_if.ready)
				sb.note_input(din_if.action, din_if.data);
			if (dout_if.valid && dout_if.ready)
				sb.check_result(dout_if.value, dout_if.last);
		end
	end

	// Result side: random stall before each word
	initial begin
		int stall;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = sink_steady ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				dout_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			dout_if.ready <= 1'b1;
			do @(posedge clk); while (!dout_if.valid);
		end
	end

	// One input word, after a random gap; valid stays high until the next call
	task automatic send_word(input logic act, input logic [7:0] dat, input bit counts);
		int gap;
		gap = src_steady ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			din_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din_if.valid <= 1'b1;
		din_if.action <= act;
		din_if.data <= dat;
		do @(posedge clk); while (!din_if.ready);
		if (counts)
			items++;
	endtask

	task automatic send_end();
		send_word(ActEnd, 8'($urandom_range(0, 255)), 1'b1);
	endtask

	// Hold the sender until every expected word has come back
	task automatic wait_results();
		din_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Idle the block fully before a direction write
	task automatic settle();
		wait_results();
		repeat (Drain) @(posedge clk);
	endtask

	task automatic write_direction(input logic d);
		cfg_we <= 1'b1;
		cfg_wdata <= d;
		@(posedge clk);
		sb.set_direction(d);
		cfg_we <= 1'b0;
		dir_now = d;
		dir_writes++;
	endtask

	function automatic int msg_length();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
	endfunction

	// Bytes to encode, biased toward all zeros and all ones
	task automatic encode_message(input int len, input bit no_end);
		logic [7:0] b;
		int         pick;
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(0, 7);
			b = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hff : 8'($urandom_range(0, 255));
			send_word(ActData, b, 1'b1);
		end
		if (!no_end)
			send_end();
	endtask

	// Well-formed symbols, or with noise a bad character and a few ignored ones after it
	task automatic decode_message(input int len, input bit noisy, input bit no_end);
		logic [7:0] c;
		int         bad_at;
		bad_at = noisy ? $urandom_range(0, len) : len + 1;
		for (int i = 0; i < len && i <= bad_at; i++) begin
			if (i == bad_at) begin
				do c = 8'($urandom_range(0, 255)); while (sb.is_symbol(c));
				send_word(ActData, c, 1'b1);
				repeat ($urandom_range(0, 3))
					send_word(ActData, 8'($urandom_range(0, 255)), 1'b0);
			end else begin
				send_word(ActData, sb.symbol_of($urandom_range(0, 63)), 1'b1);
			end
		end
		if (!no_end)
			send_end();
	endtask

	// Stimulus
	initial begin
		string text;
		int    nmsg;
		int    goal;
		int    phase;
		int    waited;
		bit    no_end;
		@(posedge clk);
		while (!arst_n) @(posedge clk);

		// encoding from reset: full groups, end with nothing held, flushes of 2 and 4 bits
		send_word(ActData, 8'h00, 1'b1);
		send_word(ActData, 8'hff, 1'b1);
		send_word(ActData, 8'hff, 1'b1);
		send_end();
		send_word(ActData, 8'h80, 1'b1);
		send_end();
		send_word(ActData, 8'h12, 1'b1);
		send_word(ActData, 8'h34, 1'b1);
		send_end();
		send_end();

		// decoding: alphabet edges, end discarding held bits, halt and its release
		settle();
		write_direction(DirDecode);
		text = "09AZaz+/";
		for (int i = 0; i < text.len(); i++)
			send_word(ActData, text[i], 1'b1);
		send_word(ActData, "Z", 1'b1);
		send_end();
		send_word(ActData, "A", 1'b1);
		send_word(ActData, 8'hff, 1'b1);
		send_word(ActData, 8'h00, 1'b0);
		send_word(ActData, "C", 1'b0);
		send_end();

		// random phases of messages, one direction write per phase
		goal = items + RandomItems;
		phase = 0;
		while (items < goal) begin
			settle();
			src_steady = ($urandom_range(0, 3) == 0);
			sink_steady = ($urandom_range(0, 3) == 0);
			write_direction((phase == 0) ? DirEncode : logic'($urandom_range(0, 1)));
			nmsg = $urandom_range(1, 5);
			for (int m = 0; m < nmsg; m++) begin
				no_end = (m == nmsg - 1) && ($urandom_range(0, 2) == 0);
				if (dir_now == DirEncode)
					encode_message(msg_length(), no_end);
				else
					decode_message(msg_length(), $urandom_range(0, 4) == 0, no_end);
				if (phase == 1 || $urandom_range(0, 7) == 0)
					wait_results();
			end
			phase++;
		end

		// drain, bounded, then look for stray words
		din_if.valid <= 1'b0;
		@(posedge clk);
		waited = 0;
		while (sb.pending() != 0 && waited < 4000) begin
			@(posedge clk);
			waited++;
		end
		repeat (Drain) @(posedge clk);
		sb.final_check();

		$display("summary: %0d input words in %0d phases, %0d direction writes",
			items, phase, dir_writes);
		$display("summary: %0d result words checked, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0) begin
			$display("radix64_codec_tb: done, clean");
		end else begin
			$display("radix64_codec_tb: done, errors");
		end
		$finish;
	end

endmodule
